// File: hdl/fskm_pkg.sv
// ----------------------------------------------------------------------------
// fskm_pkg
// Shared types, constants and the sine table of the FSK sine modulator.
// ----------------------------------------------------------------------------
package fskm_pkg;

  localparam int TABLE_POINTS = 64;
  localparam int RING_DEPTH   = 5;

  localparam int STEP_W   = 10;
  localparam int FRAC_W   = 8;
  localparam int SAMPLE_W = 12;
  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int PHASE_W  = $clog2(TABLE_POINTS * (2 ** FRAC_W) + (2 ** STEP_W));
  localparam int IDX_W    = PHASE_W - FRAC_W;
  localparam int ROM_AW   = $clog2(TABLE_POINTS);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [STEP_W-1:0] ZERO_STEP_RST = STEP_W'(486);
  localparam logic [STEP_W-1:0] ONE_STEP_RST  = STEP_W'(256);

  typedef enum logic [0:0] {
    REG_ZERO_STEP = 1'b0,
    REG_ONE_STEP  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_ZERO  = 2'd1,
    MARK_ONE   = 2'd2
  } mark_e;

  typedef enum logic [0:0] {
    MODE_PUSH = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    logic mode;
    logic bit_value;
  } in_item_t;

  typedef struct packed {
    logic                accepted;
    logic [SAMPLE_W-1:0] sample;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] zero_step;
    logic [STEP_W-1:0] one_step;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    mark_e            data;
  } ram_wr_t;

  typedef logic [TABLE_POINTS-1:0][SAMPLE_W-1:0] rom_t;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP         = 64'd2047;
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};
  localparam logic [63:0] ANGLE_DIV   = 64'd100 * 64'(TABLE_POINTS);

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic        neg;
    for (int i = 0; i < TABLE_POINTS; i++) begin
      x   = (64'(i) * 64'd628 * Q30_ONE) / ANGLE_DIV;
      neg = 1'b0;
      if (x >= PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > HALF_PI_Q30) begin
        x = PI_Q30 - x;
      end
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
        if ((k % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > Q30_ONE) begin
        sum = Q30_ONE;
      end
      sum    = neg ? (Q30_ONE - sum) : (Q30_ONE + sum);
      rom[i] = SAMPLE_W'((sum * AMP) >> 30);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

// File: hdl/fsk_sine_modulator_core.sv
// ----------------------------------------------------------------------------
// fsk_sine_modulator_core
// Binary FSK modulator: bits are pushed into a ring of slot marks, ticks walk
// a fixed-point phase through a sine table at the step of the current bit.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid_i/in_ready_o | in_item_i  (mode, bit_value)
//   out     | output    | out_valid_o/out_ready_i| out_item_o (accepted, sample)
//   cfg     | input     | APB psel/penable      | paddr, pwdata, prdata
//
// One item per cycle unless stalled; the result is registered in the cycle
// after acceptance. The slot RAM read ports are addressed by the next ring
// pointers, so every item sees its marks without waiting on the RAM.
// Reset clears pointers, phase and slot valid bits at once; no clearing pass.
// The input stalls only while the output register holds an item not taken.
// ----------------------------------------------------------------------------
module fsk_sine_modulator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  fskm_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fskm_pkg::out_item_t         out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fskm_pkg::APB_AW-1:0] paddr,
  input  logic [fskm_pkg::APB_DW-1:0] pwdata,
  output logic [fskm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  fskm_pkg::cfg_t              cfg;
  fskm_pkg::ram_wr_t           ram_wr;
  fskm_pkg::mark_e             w_mark, r_mark;
  logic [fskm_pkg::PTR_W-1:0]  wslot_q, wslot_d, rslot_q, rslot_d;
  logic [fskm_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                        second_q, second_d;
  logic                        out_valid_q, out_valid_d;
  fskm_pkg::out_item_t         out_item_q, out_item_d;
  logic                        fire, at_end, acc;
  logic [fskm_pkg::IDX_W-1:0]  idx_full;
  logic [fskm_pkg::ROM_AW-1:0] idx_clamp;

  fskm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fskm_slot_ram u_slot_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (ram_wr),
    .rd_a_addr_i (wslot_d),
    .rd_b_addr_i (rslot_d),
    .rd_a_data_o (w_mark),
    .rd_b_data_o (r_mark)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign at_end     = phase_q[fskm_pkg::PHASE_W-1:fskm_pkg::FRAC_W] >=
                      fskm_pkg::IDX_W'(fskm_pkg::TABLE_POINTS - 1);

  function automatic logic [fskm_pkg::PTR_W-1:0] ptr_next(
    input logic [fskm_pkg::PTR_W-1:0] p
  );
    return (p == fskm_pkg::PTR_W'(fskm_pkg::RING_DEPTH - 1)) ? '0 :
           p + fskm_pkg::PTR_W'(1);
  endfunction

  always_comb begin
    wslot_d     = wslot_q;
    rslot_d     = rslot_q;
    phase_d     = phase_q;
    second_d    = second_q;
    ram_wr      = '0;
    ram_wr.data = fskm_pkg::MARK_EMPTY;
    acc         = 1'b0;
    if (fire) begin
      if (in_item_i.mode == fskm_pkg::MODE_PUSH) begin
        if (w_mark == fskm_pkg::MARK_EMPTY) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = wslot_q;
          ram_wr.data = in_item_i.bit_value ? fskm_pkg::MARK_ONE : fskm_pkg::MARK_ZERO;
          wslot_d     = ptr_next(wslot_q);
          acc         = 1'b1;
        end
      end else begin
        ram_wr.addr = rslot_q;
        case (r_mark)
          fskm_pkg::MARK_ZERO: begin
            if (at_end) begin
              phase_d = '0;
              if (second_q) begin
                ram_wr.en = 1'b1;
                rslot_d   = ptr_next(rslot_q);
                second_d  = 1'b0;
              end else begin
                second_d = 1'b1;
              end
            end else begin
              phase_d = phase_q + fskm_pkg::PHASE_W'(cfg.zero_step);
            end
          end
          fskm_pkg::MARK_ONE: begin
            if (at_end) begin
              phase_d   = '0;
              ram_wr.en = 1'b1;
              rslot_d   = ptr_next(rslot_q);
            end else begin
              phase_d = phase_q + fskm_pkg::PHASE_W'(cfg.one_step);
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_comb begin
    idx_full  = phase_d[fskm_pkg::PHASE_W-1:fskm_pkg::FRAC_W];
    idx_clamp = (idx_full > fskm_pkg::IDX_W'(fskm_pkg::TABLE_POINTS - 1)) ?
                fskm_pkg::ROM_AW'(fskm_pkg::TABLE_POINTS - 1) :
                idx_full[fskm_pkg::ROM_AW-1:0];
    out_item_d = out_item_q;
    if (fire) begin
      out_item_d.accepted = acc;
      out_item_d.sample   = fskm_pkg::SINE_ROM[idx_clamp];
    end
    out_valid_d = fire || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wslot_q     <= '0;
      rslot_q     <= '0;
      phase_q     <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wslot_q     <= wslot_d;
      rslot_q     <= rslot_d;
      phase_q     <= phase_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_empty_tick_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_item_i.mode == fskm_pkg::MODE_TICK) && (r_mark != fskm_pkg::MARK_ZERO)
    && (r_mark != fskm_pkg::MARK_ONE) |=> $stable(phase_q))
    else $error("phase moved on an empty slot");

  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_item_i.mode == fskm_pkg::MODE_PUSH)
    |=> out_item_o.accepted == $past(w_mark == fskm_pkg::MARK_EMPTY))
    else $error("push result disagrees with slot mark");

  a_tick_not_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_item_i.mode == fskm_pkg::MODE_TICK) |=> !out_item_o.accepted)
    else $error("tick reported accepted");

  a_second_pass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> r_mark == fskm_pkg::MARK_ZERO)
    else $error("second pass on a slot that holds no zero bit");

endmodule

// File: hdl/fskm_slot_ram.sv
// ----------------------------------------------------------------------------
// fskm_slot_ram
// Ring slot marks: one write port, two registered read ports with
// write-through forwarding and per-entry valid bits cleared by reset.
// ----------------------------------------------------------------------------
module fskm_slot_ram (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fskm_pkg::ram_wr_t        wr_i,
  input  logic [fskm_pkg::PTR_W-1:0] rd_a_addr_i,
  input  logic [fskm_pkg::PTR_W-1:0] rd_b_addr_i,
  output fskm_pkg::mark_e          rd_a_data_o,
  output fskm_pkg::mark_e          rd_b_data_o
);

  fskm_pkg::mark_e                  mem [fskm_pkg::RING_DEPTH];
  logic [fskm_pkg::RING_DEPTH-1:0]  valid_q;
  fskm_pkg::mark_e                  rd_a_q, rd_b_q;
  fskm_pkg::mark_e                  rd_a_d, rd_b_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_comb begin
    if (wr_i.en && (wr_i.addr == rd_a_addr_i)) begin
      rd_a_d = wr_i.data;
    end else if (valid_q[rd_a_addr_i]) begin
      rd_a_d = mem[rd_a_addr_i];
    end else begin
      rd_a_d = fskm_pkg::MARK_EMPTY;
    end
    if (wr_i.en && (wr_i.addr == rd_b_addr_i)) begin
      rd_b_d = wr_i.data;
    end else if (valid_q[rd_b_addr_i]) begin
      rd_b_d = mem[rd_b_addr_i];
    end else begin
      rd_b_d = fskm_pkg::MARK_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_a_q  <= fskm_pkg::MARK_EMPTY;
      rd_b_q  <= fskm_pkg::MARK_EMPTY;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_a_q <= rd_a_d;
      rd_b_q <= rd_b_d;
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

// File: hdl/fskm_regs.sv
// ----------------------------------------------------------------------------
// fskm_regs
// APB register file holding the zero and one phase steps.
// ----------------------------------------------------------------------------
module fskm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fskm_pkg::APB_AW-1:0] paddr,
  input  logic [fskm_pkg::APB_DW-1:0] pwdata,
  output logic [fskm_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output fskm_pkg::cfg_t              cfg_o
);

  fskm_pkg::cfg_t   cfg_q, cfg_d;
  fskm_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx   = fskm_pkg::reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        fskm_pkg::REG_ZERO_STEP: cfg_d.zero_step = pwdata[fskm_pkg::STEP_W-1:0];
        fskm_pkg::REG_ONE_STEP:  cfg_d.one_step  = pwdata[fskm_pkg::STEP_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_step <= fskm_pkg::ZERO_STEP_RST;
      cfg_q.one_step  <= fskm_pkg::ONE_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      fskm_pkg::REG_ZERO_STEP: prdata = fskm_pkg::APB_DW'(cfg_q.zero_step);
      fskm_pkg::REG_ONE_STEP:  prdata = fskm_pkg::APB_DW'(cfg_q.one_step);
      default:                 prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule
